>>> sv/adaptive_local_mean_window_unit_macros.svh
// Assertion macros for the adaptive local mean window unit.
// Used by the checker; expects clk and arst_n in scope.
`ifndef ADAPTIVE_LOCAL_MEAN_WINDOW_UNIT_MACROS_SVH
`define ADAPTIVE_LOCAL_MEAN_WINDOW_UNIT_MACROS_SVH

// check on every clock edge outside reset
`define ALMW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define ALMW_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/almw_pkg.sv
// Package of the adaptive local mean window unit: sizes, register codes,
// and the command and status types between controller and datapath.
`default_nettype none
package almw_pkg;

	localparam int MAX_BASE_WINDOW = 16;
	localparam int RING_DEPTH      = 64;
	localparam int RING_AW         = $clog2(RING_DEPTH);
	localparam int NOISE_BACK      = 20;
	localparam int NOISE_FWD       = 19;
	localparam int MIN_DIST        = 4;
	localparam int LOOKAHEAD       = (2 * MAX_BASE_WINDOW > NOISE_FWD) ?
	                                 2 * MAX_BASE_WINDOW : NOISE_FWD;
	localparam int COUNT_MAX       = 127;

	localparam int Q_W     = 24;
	localparam int BASE_W  = 5;
	localparam int CNT_W   = 7;
	localparam int PEND_W  = $clog2(LOOKAHEAD + 1);
	localparam int WIN_W   = 6;
	localparam int J_W     = 7;
	localparam int POS_W   = 9;
	localparam int ACC_W   = 31;
	localparam int NCNT_W  = 6;
	localparam int T_W     = 18;
	localparam int NUM_W   = 31;
	localparam int DEN_W   = NCNT_W + 1;
	localparam int STEP_W  = 5;

	localparam int APB_DW  = 32;
	localparam int APB_AW  = 3;
	localparam int REG_IDX_BIT = 2;

	localparam logic REG_BASE_WINDOW     = 1'b0;
	localparam logic REG_ADAPTIVE_ENABLE = 1'b1;

	localparam logic [BASE_W-1:0] BASE_WINDOW_RESET = 5'd8;

	localparam logic signed [J_W-1:0] J_NOISE_LO = -(J_W'(NOISE_BACK));
	localparam logic signed [J_W-1:0] J_NOISE_HI = J_W'(NOISE_FWD);

	typedef struct packed {
		logic take;
		logic res_start;
		logic q_cap;
		logic scan_init_noise;
		logic scan_init_win;
		logic scan;
		logic nmul;
		logic ndiv_init;
		logic ndiv_step;
		logic md_init;
		logic md_step;
		logic load_out;
		logic dec_o;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic full;
		logic o_zero;
		logic adaptive;
		logic scan_last;
		logic ndiv_go;
		logic md_last;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

>>> sv/almw_ifs.sv
// Stream channel interfaces of the adaptive local mean window unit.
// Depends on almw_pkg for field widths.
`default_nettype none
interface almw_in_if import almw_pkg::*; ();
	logic valid;
	logic ready;
	logic [Q_W-1:0] sync_score;
	logic stream_end;

	modport source (output valid, output sync_score, output stream_end, input ready);
	modport sink (input valid, input sync_score, input stream_end, output ready);
endinterface

interface almw_out_if import almw_pkg::*; ();
	logic valid;
	logic ready;
	logic [Q_W-1:0] delayed_quality;
	logic [Q_W-1:0] window_avg;
	logic final_result;

	modport source (output valid, output delayed_quality, output window_avg,
		output final_result, input ready);
	modport sink (input valid, input delayed_quality, input window_avg,
		input final_result, output ready);
endinterface
`default_nettype wire

>>> sv/almw_regs.sv
// APB configuration registers: base window and adaptive enable.
// Depends on almw_pkg.
`default_nettype none
module almw_regs import almw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [BASE_W-1:0] base_window,
	output logic              adaptive_enable
);

	logic [BASE_W-1:0] base_q;
	logic              adapt_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= BASE_WINDOW_RESET;
			adapt_q <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[REG_IDX_BIT])
				REG_BASE_WINDOW:     base_q  <= pwdata[BASE_W-1:0];
				REG_ADAPTIVE_ENABLE: adapt_q <= pwdata[0];
				default:             base_q  <= base_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[REG_IDX_BIT])
			REG_BASE_WINDOW:     prdata = APB_DW'(base_q);
			REG_ADAPTIVE_ENABLE: prdata = APB_DW'(adapt_q);
			default:             prdata = '0;
		endcase
	end

	assign base_window     = base_q;
	assign adaptive_enable = adapt_q;

endmodule
`default_nettype wire

>>> sv/almw_ctrl.sv
// Sequencer of the adaptive local mean window unit: issues datapath commands
// per score and per result. Depends on almw_pkg.
`default_nettype none
module almw_ctrl import almw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_DECIDE = 5'd1;
	localparam logic [4:0] S_QADDR  = 5'd2;
	localparam logic [4:0] S_QCAP   = 5'd3;
	localparam logic [4:0] S_NINIT  = 5'd4;
	localparam logic [4:0] S_NSCAN  = 5'd5;
	localparam logic [4:0] S_NDRAIN = 5'd6;
	localparam logic [4:0] S_NMUL   = 5'd7;
	localparam logic [4:0] S_NDINIT = 5'd8;
	localparam logic [4:0] S_NDIV   = 5'd9;
	localparam logic [4:0] S_WINIT  = 5'd10;
	localparam logic [4:0] S_WSCAN  = 5'd11;
	localparam logic [4:0] S_WDRAIN = 5'd12;
	localparam logic [4:0] S_MDINIT = 5'd13;
	localparam logic [4:0] S_MDIV   = 5'd14;
	localparam logic [4:0] S_OUT    = 5'd15;
	localparam logic [4:0] S_COMMIT = 5'd16;

	logic [4:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: state_d = (st.last || st.full) ? S_QADDR : S_COMMIT;
			S_QADDR: begin
				cmd.res_start = 1'b1;
				state_d       = S_QCAP;
			end
			S_QCAP: begin
				cmd.q_cap = 1'b1;
				state_d   = st.adaptive ? S_NINIT : S_WINIT;
			end
			S_NINIT: begin
				cmd.scan_init_noise = 1'b1;
				state_d             = S_NSCAN;
			end
			S_NSCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_last)
					state_d = S_NDRAIN;
			end
			S_NDRAIN: state_d = S_NMUL;
			S_NMUL: begin
				cmd.nmul = 1'b1;
				state_d  = S_NDINIT;
			end
			S_NDINIT: begin
				cmd.ndiv_init = 1'b1;
				state_d       = S_NDIV;
			end
			S_NDIV: begin
				if (st.ndiv_go)
					cmd.ndiv_step = 1'b1;
				else
					state_d = S_WINIT;
			end
			S_WINIT: begin
				cmd.scan_init_win = 1'b1;
				state_d           = S_WSCAN;
			end
			S_WSCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_last)
					state_d = S_WDRAIN;
			end
			S_WDRAIN: state_d = S_MDINIT;
			S_MDINIT: begin
				cmd.md_init = 1'b1;
				state_d     = S_MDIV;
			end
			S_MDIV: begin
				cmd.md_step = 1'b1;
				if (st.md_last)
					state_d = S_OUT;
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					if (st.o_zero || !st.last) begin
						state_d = S_COMMIT;
					end else begin
						cmd.dec_o = 1'b1;
						state_d   = S_QADDR;
					end
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

>>> sv/almw_dp.sv
// Datapath of the adaptive local mean window unit: score ring, run counters,
// neighbour scan, noise divider, rounding divider and result register.
// Depends on almw_pkg; driven by almw_ctrl.
`default_nettype none
module almw_dp import almw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output status_t           st,
	input  logic [Q_W-1:0]    in_quality,
	input  logic              in_end,
	input  logic [BASE_W-1:0] base_window,
	input  logic              adaptive_enable,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [Q_W-1:0]    out_quality,
	output logic [Q_W-1:0]    out_mean,
	output logic              out_final
);

	logic [Q_W-1:0]     ring [RING_DEPTH];
	logic [Q_W-1:0]     cur_q, rdata_q, dq_q;
	logic               last_q;
	logic [CNT_W-1:0]   c_q, recv_q;
	logic [RING_AW-1:0] wr_q, emit_q, raddr;
	logic [PEND_W-1:0]  pend_q, o_q;

	logic signed [J_W-1:0] j_q, end_q;
	logic                  mode_q, incl_s1, cur_sel_s1;
	logic signed [POS_W-1:0] j9, o9, pos9, d9;
	logic                  in_run, keep;

	logic signed [ACC_W-1:0] acc_q, add_val, acc_mag;
	logic [NCNT_W-1:0]       cnt_q;
	logic [Q_W-1:0]          v;
	logic signed [Q_W:0]     vext;
	logic [Q_W:0]            vmag;

	logic [BASE_W-1:0]   base_eff, ext_q;
	logic [WIN_W-1:0]    window;
	logic [T_W-1:0]      t_q, macc_q;
	logic [BASE_W+29-1:0] prod;

	logic               sign_q;
	logic [NUM_W-1:0]   num_q;
	logic [DEN_W-1:0]   den_q, rem_q;
	logic [STEP_W-1:0]  step_q;
	logic [DEN_W:0]     rtry;
	logic               ge;
	logic [Q_W-1:0]     qv, mean;
	logic               out_valid_q;

	assign base_eff = (base_window > BASE_W'(MAX_BASE_WINDOW)) ?
	                  BASE_W'(MAX_BASE_WINDOW) : base_window;
	assign window   = WIN_W'(base_eff) + WIN_W'(ext_q);

	assign j9     = POS_W'(j_q);
	assign o9     = $signed(POS_W'(o_q));
	assign pos9   = $signed(POS_W'(c_q)) - o9;
	assign d9     = o9 - j9;
	assign in_run = (j9 <= o9) && ((pos9 + j9) >= 0);
	assign keep   = mode_q ? ((j_q <= -MIN_DIST) || (j_q >= MIN_DIST)) : (j_q != 0);
	assign raddr  = cmd.res_start ? (wr_q - RING_AW'(o_q)) : (wr_q - d9[RING_AW-1:0]);

	assign v       = cur_sel_s1 ? cur_q : rdata_q;
	assign vext    = $signed({v[Q_W-1], v});
	assign vmag    = v[Q_W-1] ? unsigned'(-vext) : unsigned'(vext);
	assign add_val = mode_q ? ACC_W'(vext) : $signed(ACC_W'(vmag));
	assign acc_mag = acc_q[ACC_W-1] ? -acc_q : acc_q;
	assign prod    = base_eff * acc_q[28:0];

	assign rtry = {rem_q, num_q[NUM_W-1]};
	assign ge   = rtry >= {1'b0, den_q};
	assign qv   = num_q[Q_W-1:0];
	assign mean = (cnt_q == '0) ? '0 : (sign_q ? (~qv + 1'b1) : qv);

	assign st.last      = last_q;
	assign st.full      = pend_q >= PEND_W'(LOOKAHEAD);
	assign st.o_zero    = (o_q == '0);
	assign st.adaptive  = adaptive_enable;
	assign st.scan_last = (j_q == end_q);
	assign st.ndiv_go   = (cnt_q != '0) && (ext_q < base_eff) && (macc_q <= t_q);
	assign st.md_last   = (step_q == STEP_W'(NUM_W - 1));
	assign st.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.commit)
			ring[wr_q] <= cur_q;
		rdata_q <= ring[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_q      <= '0;
			emit_q      <= '0;
			pend_q      <= '0;
			incl_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			incl_s1 <= cmd.scan && in_run && keep;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cmd.commit) begin
				if (last_q) begin
					recv_q <= '0;
					pend_q <= '0;
					emit_q <= '0;
				end else begin
					if (pend_q >= PEND_W'(LOOKAHEAD))
						emit_q <= emit_q + 1'b1;
					else
						pend_q <= pend_q + 1'b1;
					if (recv_q < CNT_W'(COUNT_MAX))
						recv_q <= recv_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_sel_s1 <= (d9 == 0);
		if (cmd.take) begin
			cur_q  <= in_quality;
			last_q <= in_end;
			c_q    <= recv_q;
			o_q    <= pend_q;
			wr_q   <= emit_q + RING_AW'(pend_q);
		end
		if (cmd.dec_o)
			o_q <= o_q - 1'b1;
		if (cmd.res_start)
			ext_q <= '0;
		if (cmd.q_cap)
			dq_q <= (o_q == '0) ? cur_q : rdata_q;

		if (cmd.scan_init_noise) begin
			j_q    <= J_NOISE_LO;
			end_q  <= J_NOISE_HI;
			mode_q <= 1'b0;
			acc_q  <= '0;
			cnt_q  <= '0;
		end else if (cmd.scan_init_win) begin
			j_q    <= -$signed(J_W'(window));
			end_q  <= $signed(J_W'(window));
			mode_q <= 1'b1;
			acc_q  <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.scan)
				j_q <= j_q + 1'b1;
			if (incl_s1) begin
				acc_q <= acc_q + add_val;
				cnt_q <= cnt_q + 1'b1;
			end
		end

		if (cmd.nmul)
			t_q <= prod[BASE_W+29-1:16];
		if (cmd.ndiv_init) begin
			ext_q  <= '0;
			macc_q <= T_W'(cnt_q);
		end else if (cmd.ndiv_step) begin
			ext_q  <= ext_q + 1'b1;
			macc_q <= macc_q + T_W'(cnt_q);
		end

		if (cmd.md_init) begin
			sign_q <= acc_q[ACC_W-1];
			num_q  <= {acc_mag[NUM_W-2:0], 1'b0} + NUM_W'(cnt_q);
			den_q  <= {cnt_q, 1'b0};
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.md_step) begin
			rem_q  <= ge ? DEN_W'(rtry - {1'b0, den_q}) : rtry[DEN_W-1:0];
			num_q  <= {num_q[NUM_W-2:0], ge};
			step_q <= step_q + 1'b1;
		end

		if (cmd.load_out) begin
			out_quality <= dq_q;
			out_mean    <= mean;
			out_final   <= last_q && (o_q == '0);
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

>>> sv/adaptive_local_mean_window_unit.sv
// Adaptive local mean window unit: a score that gives no result passes only the
// take, decide and commit states; each result takes longer with the base window w
// and, in adaptive mode, with the window extension e (up to 16), set by the single
// ring read port walking the neighbours and the 31-step rounding divider.
// A final score gives all pending results and its own one after another.
// Reset (arst_n low): counters and out_valid cleared; ring and result data undefined.
`default_nettype none
module adaptive_local_mean_window_unit import almw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	almw_in_if.sink           scores,
	almw_out_if.source        results
);

	logic [BASE_W-1:0] base_window;
	logic              adaptive_enable;
	cmd_t              cmd;
	status_t           st;

	almw_regs u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.base_window     (base_window),
		.adaptive_enable (adaptive_enable)
	);

	almw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (scores.valid),
		.in_ready (scores.ready),
		.st       (st),
		.cmd      (cmd)
	);

	almw_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.in_quality      (scores.sync_score),
		.in_end          (scores.stream_end),
		.base_window     (base_window),
		.adaptive_enable (adaptive_enable),
		.out_valid       (results.valid),
		.out_ready       (results.ready),
		.out_quality     (results.delayed_quality),
		.out_mean        (results.window_avg),
		.out_final       (results.final_result)
	);

endmodule
`default_nettype wire

>>> sv/almw_checker.sv
// Port-level checker for the adaptive local mean window unit, bound to the top.
// Depends on almw_pkg and the assertion macro header.
`default_nettype none
`include "adaptive_local_mean_window_unit_macros.svh"
module almw_checker import almw_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input logic [Q_W-1:0] out_quality,
	input logic [Q_W-1:0] out_mean,
	input logic           out_final
);

	logic [2*Q_W:0] out_word;

	assign out_word = {out_quality, out_mean, out_final};

	`ALMW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_word), "stalled result lost")
	`ALMW_ASSERT(a_one_request, in_valid && in_ready |=> !in_ready, "second request taken")
	`ALMW_ASSERT(a_result_busy, $rose(out_valid) |-> !in_ready, "result raised while idle")
	`ALMW_ASSERT_RST(a_reset_quiet, !arst_n |-> !out_valid, "result valid during reset")

endmodule

bind adaptive_local_mean_window_unit almw_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (scores.valid),
	.in_ready    (scores.ready),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.out_quality (results.delayed_quality),
	.out_mean    (results.window_avg),
	.out_final   (results.final_result)
);
`default_nettype wire
